>>> hw/rtl/lfs_pkg.sv
`default_nettype none
package lfs_pkg;

  localparam int unsigned LVL_W     = 8;
  localparam int unsigned SUM_W     = 12;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned DIV_W     = 2 * LVL_W;
  localparam int unsigned DIV_RADIX = 2;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W / DIV_RADIX);
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  localparam logic [1:0] REG_LIGHT_CEILING = 2'd0;
  localparam logic [1:0] REG_DRIVE_MAX     = 2'd1;
  localparam logic [1:0] REG_DEAD_LEVEL    = 2'd2;
  localparam logic [1:0] REG_TURN_GAP      = 2'd3;

  localparam logic [LVL_W-1:0] RST_LIGHT_CEILING = 8'd250;
  localparam logic [LVL_W-1:0] RST_DRIVE_MAX     = 8'd255;
  localparam logic [LVL_W-1:0] RST_DEAD_LEVEL    = 8'd10;
  localparam logic [LVL_W-1:0] RST_TURN_GAP      = 8'd75;

  localparam logic [1:0] MODE_PIVOT_RIGHT = 2'd0;
  localparam logic [1:0] MODE_PIVOT_LEFT  = 2'd1;
  localparam logic [1:0] MODE_PROP        = 2'd2;
  localparam logic [1:0] MODE_STOP        = 2'd3;

  // bit 0 drives pin a, bit 1 drives pin b
  localparam logic [1:0] PINS_PIVOT_RIGHT = 2'b10;
  localparam logic [1:0] PINS_PIVOT_LEFT  = 2'b01;
  localparam logic [1:0] PINS_PROP        = 2'b00;

  typedef struct packed {
    logic [LVL_W-1:0] light_ceiling;
    logic [LVL_W-1:0] drive_max;
    logic [LVL_W-1:0] dead_level;
    logic [LVL_W-1:0] turn_gap;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic store_amb;
    logic load_mul_r;
    logic load_mul_l;
    logic div_step;
    logic store_dr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic cal_full;
    logic div_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/lfs_if.sv
`default_nettype none
interface lfs_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [lfs_pkg::LVL_W-1:0]  right_level;
  logic [lfs_pkg::LVL_W-1:0]  left_level;

  modport source (output valid, output op, output right_level, output left_level,
                  input ready);
  modport sink   (input valid, input op, input right_level, input left_level,
                  output ready);
endinterface

interface lfs_out_if;
  logic                       valid;
  logic                       ready;
  logic [lfs_pkg::LVL_W-1:0]  left_drive;
  logic [lfs_pkg::LVL_W-1:0]  right_drive;
  logic [1:0]                 steer_mode;
  logic                       direction_pin_a;
  logic                       direction_pin_b;

  modport source (output valid, output left_drive, output right_drive, output steer_mode,
                  output direction_pin_a, output direction_pin_b, input ready);
  modport sink   (input valid, input left_drive, input right_drive, input steer_mode,
                  input direction_pin_a, input direction_pin_b, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/light_follow_steering_unit.sv
`default_nettype none
// Light-following steering. Each input transfer carries a left and right light sample;
// op 0 is a calibration sample and op 1 a drive sample. The calibration sample that
// completes a set of SAMPLES also loads both ambient levels with the set averages (a
// constant reciprocal multiply) in the next cycle and holds the input off meanwhile.
// A drive sample yields one result transfer, and the input takes no further sample until
// that result is loaded into the output register (held off while a waiting result
// stalls the output): the single 8x8 multiplier and one shared restoring divider,
// retiring two quotient bits per cycle, are run once per side. One result may sit in
// the output register while the next sample is being worked on. Registers:
// light_ceiling at 0x0, drive_max at 0x4, dead_level at 0x8, turn_gap at 0xC; write
// only while the block is idle.
module light_follow_steering_unit #(
  parameter int unsigned SAMPLES = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  lfs_in_if.sink                           in_i,
  lfs_out_if.source                        out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lfs_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lfs_pkg::DATA_W-1:0]  pwdata,
  output logic      [lfs_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  lfs_pkg::cfg_t    cfg;
  lfs_pkg::cmd_t    cmd;
  lfs_pkg::status_t status;
  logic             in_ready;

  lfs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfs_datapath #(
    .SAMPLES (SAMPLES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_i             (cfg),
    .in_op_i           (in_i.op),
    .in_right_level_i  (in_i.right_level),
    .in_left_level_i   (in_i.left_level),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_left_drive_o  (out_o.left_drive),
    .out_right_drive_o (out_o.right_drive),
    .out_steer_mode_o  (out_o.steer_mode),
    .out_pin_a_o       (out_o.direction_pin_a),
    .out_pin_b_o       (out_o.direction_pin_b)
  );

  assign in_i.ready = in_ready;

endmodule
`default_nettype wire

>>> hw/rtl/lfs_cfg_regs.sv
`default_nettype none
module lfs_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lfs_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [lfs_pkg::DATA_W-1:0]   pwdata,
  output logic      [lfs_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output lfs_pkg::cfg_t                     cfg_o
);

  lfs_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [lfs_pkg::LVL_W-1:0] rd_val;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        lfs_pkg::REG_LIGHT_CEILING: cfg_d.light_ceiling = pwdata[lfs_pkg::LVL_W-1:0];
        lfs_pkg::REG_DRIVE_MAX:     cfg_d.drive_max     = pwdata[lfs_pkg::LVL_W-1:0];
        lfs_pkg::REG_DEAD_LEVEL:    cfg_d.dead_level    = pwdata[lfs_pkg::LVL_W-1:0];
        lfs_pkg::REG_TURN_GAP:      cfg_d.turn_gap      = pwdata[lfs_pkg::LVL_W-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lfs_pkg::REG_LIGHT_CEILING: rd_val = cfg_q.light_ceiling;
      lfs_pkg::REG_DRIVE_MAX:     rd_val = cfg_q.drive_max;
      lfs_pkg::REG_DEAD_LEVEL:    rd_val = cfg_q.dead_level;
      lfs_pkg::REG_TURN_GAP:      rd_val = cfg_q.turn_gap;
      default:                    rd_val = '0;
    endcase
  end

  assign prdata = {{(lfs_pkg::DATA_W - lfs_pkg::LVL_W){1'b0}}, rd_val};
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_ceiling <= lfs_pkg::RST_LIGHT_CEILING;
      cfg_q.drive_max     <= lfs_pkg::RST_DRIVE_MAX;
      cfg_q.dead_level    <= lfs_pkg::RST_DEAD_LEVEL;
      cfg_q.turn_gap      <= lfs_pkg::RST_TURN_GAP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lfs_ctrl.sv
`default_nettype none
module lfs_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire lfs_pkg::status_t status_i,
  output lfs_pkg::cmd_t         cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b000_0001,
    S_CAL    = 7'b000_0010,
    S_MUL_R  = 7'b000_0100,
    S_DIV_R  = 7'b000_1000,
    S_MUL_L  = 7'b001_0000,
    S_DIV_L  = 7'b010_0000,
    S_DECIDE = 7'b100_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.op) begin
            state_d = S_MUL_R;
          end else if (status_i.cal_full) begin
            state_d = S_CAL;
          end
        end
      end
      S_CAL: begin
        cmd_o.store_amb = 1'b1;
        state_d         = S_IDLE;
      end
      S_MUL_R: begin
        cmd_o.load_mul_r = 1'b1;
        state_d          = S_DIV_R;
      end
      S_DIV_R: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_MUL_L;
      end
      S_MUL_L: begin
        cmd_o.store_dr   = 1'b1;
        cmd_o.load_mul_l = 1'b1;
        state_d          = S_DIV_L;
      end
      S_DIV_L: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lfs_datapath.sv
`default_nettype none
module lfs_datapath #(
  parameter int unsigned SAMPLES = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lfs_pkg::cmd_t               cmd_i,
  output lfs_pkg::status_t                 status_o,
  input  wire lfs_pkg::cfg_t               cfg_i,
  input  wire logic                        in_op_i,
  input  wire logic [lfs_pkg::LVL_W-1:0]   in_right_level_i,
  input  wire logic [lfs_pkg::LVL_W-1:0]   in_left_level_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic      [lfs_pkg::LVL_W-1:0]   out_left_drive_o,
  output logic      [lfs_pkg::LVL_W-1:0]   out_right_drive_o,
  output logic      [1:0]                  out_steer_mode_o,
  output logic                             out_pin_a_o,
  output logic                             out_pin_b_o
);

  localparam int unsigned LW  = lfs_pkg::LVL_W;
  localparam int unsigned SW  = lfs_pkg::SUM_W;
  localparam int unsigned CW  = lfs_pkg::CNT_W;
  localparam int unsigned DW  = lfs_pkg::DIV_W;
  localparam int unsigned DCW = lfs_pkg::DIV_CNT_W;

  // sum / SAMPLES as sum * ceil(2^RSH / SAMPLES) >> RSH, exact for every SW-bit sum
  localparam int unsigned RSH   = SW + CW;
  localparam int unsigned RW    = RSH + 1;
  localparam int unsigned RECIP = ((1 << RSH) + SAMPLES - 1) / SAMPLES;

  function automatic logic [LW-1:0] offset_above(input logic [LW-1:0] level,
                                                 input logic [LW-1:0] amb,
                                                 input logic [LW-1:0] ceil_lvl);
    logic [LW-1:0] clamped;
    if (level <= amb) begin
      clamped = amb;
    end else if (level > ceil_lvl) begin
      clamped = ceil_lvl;
    end else begin
      clamped = level;
    end
    return clamped - amb;
  endfunction

  // calibration state
  logic [SW-1:0] sum_r_q, sum_r_d, sum_l_q, sum_l_d;
  logic [CW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [LW-1:0] amb_r_q, amb_r_d, amb_l_q, amb_l_d;
  logic          cal_full;
  logic [SW+RW-1:0] avg_r_prod, avg_l_prod;

  // latched levels
  logic [LW-1:0] lvl_r_q, lvl_l_q;

  // shared divider
  logic [DW-1:0]  quo_q, quo_d;
  logic [LW-1:0]  rem_q, rem_d;
  logic [LW-1:0]  dvs_q, dvs_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;

  logic [LW-1:0] mul_a, den;
  logic [DW-1:0] product;
  logic          amb_ge_r, amb_ge_l;

  // decision
  logic [LW-1:0] dr_q, dl;
  logic [LW-1:0] diff;
  logic [LW-1:0] lo, ro;
  logic [1:0]    mode;
  logic [1:0]    pin_q, pin_d;

  logic          out_valid_q;
  logic [LW-1:0] out_lo_q, out_ro_q;
  logic [1:0]    out_mode_q;

  assign cnt_inc  = cnt_q + CW'(1);
  assign cal_full = (cnt_inc >= CW'(SAMPLES));

  assign status_o.op       = in_op_i;
  assign status_o.cal_full = cal_full;
  assign status_o.div_last = (dcnt_q == '1);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign avg_r_prod = {{RW{1'b0}}, sum_r_q} * {{SW{1'b0}}, RW'(RECIP)};
  assign avg_l_prod = {{RW{1'b0}}, sum_l_q} * {{SW{1'b0}}, RW'(RECIP)};

  always_comb begin
    sum_r_d = sum_r_q;
    sum_l_d = sum_l_q;
    cnt_d   = cnt_q;
    amb_r_d = amb_r_q;
    amb_l_d = amb_l_q;
    if (cmd_i.accept && !in_op_i) begin
      sum_r_d = sum_r_q + {{(SW - LW){1'b0}}, in_right_level_i};
      sum_l_d = sum_l_q + {{(SW - LW){1'b0}}, in_left_level_i};
      cnt_d   = cal_full ? '0 : cnt_inc;
    end
    if (cmd_i.store_amb) begin
      amb_r_d = avg_r_prod[RSH +: LW];
      amb_l_d = avg_l_prod[RSH +: LW];
      sum_r_d = '0;
      sum_l_d = '0;
    end
  end

  assign amb_ge_r = (amb_r_q >= cfg_i.light_ceiling);
  assign amb_ge_l = (amb_l_q >= cfg_i.light_ceiling);

  assign mul_a   = cmd_i.load_mul_r ? offset_above(lvl_r_q, amb_r_q, cfg_i.light_ceiling)
                                    : offset_above(lvl_l_q, amb_l_q, cfg_i.light_ceiling);
  assign den     = cmd_i.load_mul_r ? (cfg_i.light_ceiling - amb_r_q)
                                    : (cfg_i.light_ceiling - amb_l_q);
  assign product = {{LW{1'b0}}, mul_a} * {{LW{1'b0}}, cfg_i.drive_max};

  // restoring divider, two quotient bits per cycle
  always_comb begin
    logic [LW:0]   part;
    logic [DW-1:0] q;
    logic [LW-1:0] r;
    q      = quo_q;
    r      = rem_q;
    part   = '0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dcnt_d = dcnt_q;
    if (cmd_i.load_mul_r || cmd_i.load_mul_l) begin
      quo_d  = product;
      rem_d  = '0;
      dvs_d  = den;
      dcnt_d = '0;
    end else if (cmd_i.div_step) begin
      for (int k = 0; k < lfs_pkg::DIV_RADIX; k++) begin
        part = {r, q[DW-1]};
        q    = {q[DW-2:0], 1'b0};
        if (part >= {1'b0, dvs_q}) begin
          part = part - {1'b0, dvs_q};
          q[0] = 1'b1;
        end
        r = part[LW-1:0];
      end
      quo_d  = q;
      rem_d  = r;
      dcnt_d = dcnt_q + DCW'(1);
    end
  end

  assign dl   = amb_ge_l ? '0 : quo_q[LW-1:0];
  assign diff = (dr_q > dl) ? (dr_q - dl) : (dl - dr_q);

  always_comb begin
    pin_d = pin_q;
    priority if (dr_q > cfg_i.dead_level && dl > cfg_i.dead_level) begin
      if (diff > cfg_i.turn_gap) begin
        if (dl < dr_q) begin
          lo    = dr_q;
          ro    = dr_q;
          mode  = lfs_pkg::MODE_PIVOT_RIGHT;
          pin_d = lfs_pkg::PINS_PIVOT_RIGHT;
        end else begin
          lo    = dl;
          ro    = dl;
          mode  = lfs_pkg::MODE_PIVOT_LEFT;
          pin_d = lfs_pkg::PINS_PIVOT_LEFT;
        end
      end else begin
        lo    = dl;
        ro    = dr_q;
        mode  = lfs_pkg::MODE_PROP;
        pin_d = lfs_pkg::PINS_PROP;
      end
    end else begin
      lo   = '0;
      ro   = '0;
      mode = lfs_pkg::MODE_STOP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_r_q     <= '0;
      sum_l_q     <= '0;
      cnt_q       <= '0;
      amb_r_q     <= '0;
      amb_l_q     <= '0;
      pin_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_r_q <= sum_r_d;
      sum_l_q <= sum_l_d;
      cnt_q   <= cnt_d;
      amb_r_q <= amb_r_d;
      amb_l_q <= amb_l_d;
      if (cmd_i.finish) begin
        pin_q       <= pin_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    dcnt_q <= dcnt_d;
    if (cmd_i.accept) begin
      lvl_r_q <= in_right_level_i;
      lvl_l_q <= in_left_level_i;
    end
    if (cmd_i.store_dr) dr_q <= amb_ge_r ? '0 : quo_q[LW-1:0];
    if (cmd_i.finish) begin
      out_lo_q   <= lo;
      out_ro_q   <= ro;
      out_mode_q <= mode;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_left_drive_o  = out_lo_q;
  assign out_right_drive_o = out_ro_q;
  assign out_steer_mode_o  = out_mode_q;
  assign out_pin_a_o       = pin_q[0];
  assign out_pin_b_o       = pin_q[1];

`ifndef SYNTHESIS
  a_finish_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending transfer");

  a_stop_holds_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && mode == lfs_pkg::MODE_STOP) |=> (pin_q == $past(pin_q)))
    else $error("direction pins changed on stop");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && dvs_q != '0) |-> (rem_q < dvs_q))
    else $error("divider remainder out of range");

  a_cnt_below_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CW'(SAMPLES))
    else $error("calibration count passed sample total");
`endif

endmodule
`default_nettype wire
